FILE: hdl/bfr_pkg.sv
// Shared types and constants for the bitmap font text renderer.
// Holds the microcode word layout, the microcode table and stream field offsets.
// No dependencies.
`default_nettype none

package bfr_pkg;

  // stream and config widths
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned COORD_W     = 13;

  // input tdata field offsets
  localparam int unsigned CODE_LSB  = 0;
  localparam int unsigned GROW_LSB  = 8;
  localparam int unsigned BITS_LSB  = 12;
  localparam int unsigned FIRST_BIT = 20;
  localparam int unsigned SX_LSB    = 21;
  localparam int unsigned SY_LSB    = 33;
  localparam int unsigned COLOR_LSB = 45;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [13:0] CURSOR_MAX   = 14'd8191;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic REQ_FONT_LOAD = 1'b0;

  typedef logic [2:0] upc_t;

  localparam upc_t UPC_FETCH   = 3'd0;
  localparam upc_t UPC_DECODE  = 3'd1;
  localparam upc_t UPC_NLCHK   = 3'd2;
  localparam upc_t UPC_SETUP   = 3'd3;
  localparam upc_t UPC_EMIT    = 3'd4;
  localparam upc_t UPC_ADVANCE = 3'd5;
  localparam upc_t UPC_LOAD    = 3'd6;
  localparam upc_t UPC_NEWLINE = 3'd7;

  typedef enum logic [2:0] {
    COND_ALWAYS    = 3'd0,
    COND_NO_INPUT  = 3'd1,
    COND_IS_LOAD   = 3'd2,
    COND_IS_NL     = 3'd3,
    COND_MORE_ROWS = 3'd4
  } cond_e;

  // one control word; jump to target when cond holds, else fall through
  typedef struct packed {
    logic  accept;
    logic  first_en;
    logic  load_en;
    logic  nl_en;
    logic  setup_en;
    logic  emit_en;
    logic  adv_en;
    cond_e cond;
    upc_t  target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic is_load;
    logic is_nl;
    logic more_rows;
    logic stall;
  } status_t;

  function automatic ucode_t ucode_rom(input upc_t pc);
    ucode_t w;
    w = '0;
    unique case (pc)
      UPC_FETCH: begin
        w.accept = 1'b1;
        w.cond   = COND_NO_INPUT;
        w.target = UPC_FETCH;
      end
      UPC_DECODE: begin
        w.first_en = 1'b1;
        w.cond     = COND_IS_LOAD;
        w.target   = UPC_LOAD;
      end
      UPC_NLCHK: begin
        w.cond   = COND_IS_NL;
        w.target = UPC_NEWLINE;
      end
      UPC_SETUP: begin
        w.setup_en = 1'b1;
        w.cond     = COND_ALWAYS;
        w.target   = UPC_EMIT;
      end
      UPC_EMIT: begin
        w.emit_en = 1'b1;
        w.cond    = COND_MORE_ROWS;
        w.target  = UPC_EMIT;
      end
      UPC_ADVANCE: begin
        w.adv_en = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = UPC_FETCH;
      end
      UPC_LOAD: begin
        w.load_en = 1'b1;
        w.cond    = COND_ALWAYS;
        w.target  = UPC_FETCH;
      end
      UPC_NEWLINE: begin
        w.nl_en  = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = UPC_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/bfr_sequencer.sv
// Microcode sequencer: step counter, control word lookup and conditional jumps.
// Depends on bfr_pkg.
`default_nettype none

module bfr_sequencer (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire bfr_pkg::status_t stat_i,
  output bfr_pkg::ucode_t       ctrl_o
);
  import bfr_pkg::*;

  upc_t   pc_q, pc_d;
  ucode_t cw;
  logic   take;

  assign cw     = ucode_rom(pc_q);
  assign ctrl_o = cw;

  always_comb begin
    unique case (cw.cond)
      COND_ALWAYS:    take = 1'b1;
      COND_NO_INPUT:  take = !stat_i.in_valid;
      COND_IS_LOAD:   take = stat_i.is_load;
      COND_IS_NL:     take = stat_i.is_nl;
      COND_MORE_ROWS: take = stat_i.more_rows;
      default:        take = 1'b1;
    endcase
  end

  always_comb begin
    priority if (cw.emit_en && stat_i.stall) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = cw.target;
    end else begin
      pc_d = pc_q + upc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= UPC_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.emit_en && stat_i.stall) |=> (pc_q == UPC_EMIT))
    else $error("emit step left while output stalled");

  a_load_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cw.load_en |=> (pc_q == UPC_FETCH))
    else $error("font load did not return to fetch");

  a_fetch_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.accept && !stat_i.in_valid) |=> (pc_q == UPC_FETCH))
    else $error("sequencer left fetch without a transfer");

endmodule

`default_nettype wire

FILE: hdl/bfr_datapath.sv
// Datapath: item latch, cursor, screen registers, font store, row generator, output register.
// Driven by the control word from bfr_sequencer; depends on bfr_pkg.
`default_nettype none

module bfr_datapath #(
  parameter int unsigned GLYPH_ROWS  = 16,
  parameter int unsigned GLYPH_COUNT = 256
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  input  wire logic [bfr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  wire logic                               s_axis_tuser,
  input  wire logic                               cfg_valid_i,
  input  wire logic [bfr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [bfr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire bfr_pkg::ucode_t                    ctrl_i,
  output bfr_pkg::status_t                        stat_o,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [bfr_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  output logic                                    m_axis_tlast
);
  import bfr_pkg::*;

  localparam int unsigned CW = $clog2(GLYPH_COUNT);
  localparam int unsigned RW = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int unsigned FONT_DEPTH = 2 ** (CW + RW);

  // latched item
  logic                 req_q;
  logic [7:0]           code_q;
  logic [3:0]           grow_q;
  logic [7:0]           bits_q;
  logic                 first_q;
  logic [11:0]          sx_q, sy_q;
  logic [31:0]          color_q;

  logic [COORD_W-1:0]   col_q, col_d, row_cur_q, row_cur_d;
  logic [11:0]          line_q, line_d;
  logic [COORD_W-1:0]   width_q, height_q;

  logic [RW-1:0]        row_q, row_d;
  logic [23:0]          addr_q;
  logic [13:0]          py_q;
  logic [7:0]           hmask_q;
  logic [7:0]           rd_q;
  logic [7:0]           font_mem [FONT_DEPTH];

  logic                 in_fire, emit_fire, stall, more_rows;
  logic                 code_ok, load_ok, py_ok;
  logic [CW+RW-1:0]     waddr, raddr;
  logic [26:0]          base_full;
  logic [13:0]          col_sum, row_sum;
  logic [7:0]           hmask_d;

  logic                 out_valid_q;
  logic [23:0]          out_addr_q;
  logic [7:0]           out_mask_q;
  logic [31:0]          out_color_q;
  logic                 out_last_q;

  assign in_fire   = ctrl_i.accept && s_axis_tvalid;
  assign stall     = out_valid_q && !m_axis_tready;
  assign emit_fire = ctrl_i.emit_en && !stall;
  assign more_rows = (row_q != RW'(GLYPH_ROWS - 1));

  assign code_ok = ({1'b0, code_q} < 9'(GLYPH_COUNT));
  assign load_ok = ({2'b00, grow_q} < 6'(GLYPH_ROWS)) && code_ok;
  assign py_ok   = (py_q < {1'b0, height_q});

  assign stat_o.in_valid  = s_axis_tvalid;
  assign stat_o.is_load   = (req_q == REQ_FONT_LOAD);
  assign stat_o.is_nl     = (code_q == NEWLINE_CODE);
  assign stat_o.more_rows = more_rows;
  assign stat_o.stall     = stall;

  // row counter runs ahead of the registered font read: the read address takes row_d
  always_comb begin
    row_d = row_q;
    if (ctrl_i.setup_en) begin
      row_d = '0;
    end else if (emit_fire) begin
      row_d = row_q + RW'(1);
    end
  end

  assign waddr = {CW'(code_q), RW'(grow_q)};
  assign raddr = {CW'(code_q), row_d};

  assign base_full = ({14'b0, row_cur_q} * {14'b0, width_q}) + {14'b0, col_q};

  always_comb begin
    for (int dx = 0; dx < 8; dx++) begin
      hmask_d[7-dx] = (({1'b0, col_q} + 14'(dx)) < {1'b0, width_q});
    end
  end

  // cursor updates
  always_comb begin
    col_d     = col_q;
    row_cur_d = row_cur_q;
    line_d    = line_q;
    col_sum   = {1'b0, col_q} + 14'd8;
    row_sum   = {1'b0, row_cur_q} + 14'(GLYPH_ROWS);
    if (ctrl_i.first_en && (req_q != REQ_FONT_LOAD) && first_q) begin
      col_d     = {1'b0, sx_q};
      row_cur_d = {1'b0, sy_q};
      line_d    = sx_q;
    end
    if (ctrl_i.nl_en) begin
      col_d     = {1'b0, line_q};
      row_cur_d = (row_sum > CURSOR_MAX) ? CURSOR_MAX[COORD_W-1:0] : row_sum[COORD_W-1:0];
    end
    if (ctrl_i.adv_en) begin
      col_d = (col_sum > CURSOR_MAX) ? CURSOR_MAX[COORD_W-1:0] : col_sum[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_cur_q   <= '0;
      line_q      <= '0;
      width_q     <= COORD_W'(640);
      height_q    <= COORD_W'(480);
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_cur_q <= row_cur_d;
      line_q    <= line_d;
      row_q     <= row_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
          CFG_SCREEN_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q   <= s_axis_tuser;
      code_q  <= s_axis_tdata[CODE_LSB +: 8];
      grow_q  <= s_axis_tdata[GROW_LSB +: 4];
      bits_q  <= s_axis_tdata[BITS_LSB +: 8];
      first_q <= s_axis_tdata[FIRST_BIT];
      sx_q    <= s_axis_tdata[SX_LSB +: 12];
      sy_q    <= s_axis_tdata[SY_LSB +: 12];
      color_q <= s_axis_tdata[COLOR_LSB +: 32];
    end
    if (ctrl_i.setup_en) begin
      addr_q  <= base_full[23:0];
      py_q    <= {1'b0, row_cur_q};
      hmask_q <= hmask_d;
    end else if (emit_fire) begin
      addr_q <= addr_q + 24'(width_q);
      py_q   <= py_q + 14'd1;
    end
    if (emit_fire) begin
      out_addr_q  <= py_ok ? addr_q : '0;
      out_mask_q  <= (py_ok && code_ok) ? (rd_q & hmask_q) : '0;
      out_color_q <= color_q;
      out_last_q  <= !more_rows;
    end
  end

  // font store
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_en && load_ok) begin
      font_mem[waddr] <= bits_q;
    end
    rd_q <= font_mem[raddr];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_color_q, out_mask_q, out_addr_q};
  assign m_axis_tlast  = out_last_q;

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl_i.emit_en))
    else $error("output valid without an emit step");

  a_setup_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.setup_en |=> (row_q == '0))
    else $error("row counter not cleared by setup");

  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && !py_ok) |=> (out_addr_q == '0 && out_mask_q == '0))
    else $error("clipped row carries address or mask");

endmodule

`default_nettype wire

FILE: hdl/bitmap_font_text_renderer.sv
// Top level of the bitmap font text renderer: microcode sequencer plus datapath.
// Depends on bfr_pkg, bfr_sequencer and bfr_datapath.
//
//   channel   direction  handshake                        payload
//   s_axis    in         s_axis_tvalid / s_axis_tready    tdata[76:0], tuser = req_type
//   m_axis    out        m_axis_tvalid / m_axis_tready    tdata[63:0], tlast = last_row
//   cfg       in         cfg_valid_i / cfg_ready_o        cfg_index_i, cfg_data_i
//
// A character runs fetch, decode, newline check, setup, one emit step per glyph row
// and cursor advance; loads branch to the load step at decode, newlines at newline check.
// The emit step, one row per cycle, holds while m_axis_tready stalls the output register.
// Reset clears the cursor and loads 640x480; the font store holds no reset value and
// must be loaded before characters that use it are drawn.
// cfg_ready_o is always high; each write lands in the screen registers in the cycle after it.
`default_nettype none

module bitmap_font_text_renderer #(
  parameter int unsigned GLYPH_ROWS  = 16,
  parameter int unsigned GLYPH_COUNT = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] char_code, [11:8] glyph_row, [19:12] font_bits, [20] first_char,
  // [32:21] start_x, [44:33] start_y, [76:45] color, [79:77] zero
  input  wire logic [bfr_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // [0] req_type
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [23:0] pixel_addr, [31:24] pixel_mask, [63:32] pixel_color
  output logic [bfr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [bfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bfr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bfr_pkg::*;

  ucode_t  ctrl;
  status_t stat;

  assign s_axis_tready = ctrl.accept;
  assign cfg_ready_o   = 1'b1;

  bfr_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  bfr_datapath #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: test/bitmap_font_text_renderer_tb.sv
// Self-checking testbench for bitmap_font_text_renderer: glyph loads, character
// drawing with clipping, newlines, cursor moves and screen size changes.
// Depends on bfr_pkg and the RTL of the block only.
module bitmap_font_text_renderer_tb;
  import bfr_pkg::*;

  localparam int unsigned GLYPH_ROWS    = 16;
  localparam int unsigned SETTLE_CYCLES = 8;   // margin for a trailing load or newline to finish in the block
  localparam int unsigned DRAIN_CYCLES  = 40;  // margin for a trailing character to finish in the block
  localparam int unsigned RANDOM_ITEMS  = 150;
  localparam longint unsigned TIMEOUT_NS = 64'd40_000_000;

  // one accepted request, fields as on the input stream
  typedef struct packed {
    logic        req_type;
    logic [31:0] color;
    logic [11:0] sy;
    logic [11:0] sx;
    logic        first;
    logic [7:0]  bits;
    logic [3:0]  grow;
    logic [7:0]  code;
  } text_req_t;

  typedef struct packed {
    logic [23:0] addr;
    logic [7:0]  mask;
    logic [31:0] color;
    logic        last;
  } row_write_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  bitmap_font_text_renderer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  class render_scoreboard;
    row_write_t  expected_rows[$];
    logic [7:0]  glyph_mem [0:4095];
    int unsigned cur_col, cur_row, line_col;
    int unsigned scr_width, scr_height;
    int unsigned mismatches, rows_checked, chars_drawn, newlines, rows_loaded;

    function new();
      cur_col = 0;
      cur_row = 0;
      line_col = 0;
      scr_width = 640;
      scr_height = 480;
    endfunction

    function int unsigned clamp_cursor(int unsigned v);
      return (v > CURSOR_MAX) ? int'(CURSOR_MAX) : v;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_SCREEN_WIDTH) scr_width = data;
      else if (idx == CFG_SCREEN_HEIGHT) scr_height = data;
    endfunction

    // predict the row writes caused by one accepted request
    function void note_input(text_req_t r);
      int unsigned hmask;
      int unsigned py;
      row_write_t  w;
      if (r.req_type == REQ_FONT_LOAD) begin
        glyph_mem[{r.code, r.grow}] = r.bits;
        rows_loaded++;
        return;
      end
      if (r.first) begin
        cur_col  = r.sx;
        cur_row  = r.sy;
        line_col = r.sx;
      end
      if (r.code == NEWLINE_CODE) begin
        cur_col = line_col;
        cur_row = clamp_cursor(cur_row + GLYPH_ROWS);
        newlines++;
        return;
      end
      hmask = 0;
      for (int dx = 0; dx < 8; dx++)
        if (cur_col + dx < scr_width) hmask |= 32'h80 >> dx;
      for (int dy = 0; dy < GLYPH_ROWS; dy++) begin
        py = cur_row + dy;
        w.addr = '0;
        w.mask = '0;
        if (py < scr_height) begin
          w.addr = 24'(py * scr_width + cur_col);
          w.mask = 8'(glyph_mem[{r.code, 4'(dy)}] & hmask);
        end
        w.color = r.color;
        w.last  = (dy == GLYPH_ROWS - 1);
        expected_rows.push_back(w);
      end
      cur_col = clamp_cursor(cur_col + 8);
      chars_drawn++;
    endfunction

    function void check_row(logic [OUT_TDATA_W-1:0] data, logic last);
      row_write_t got, exp;
      got = {data[23:0], data[31:24], data[63:32], last};
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected row write: addr=%h mask=%h color=%h last=%b",
                   got.addr, got.mask, got.color, got.last);
        return;
      end
      exp = expected_rows.pop_front();
      rows_checked++;
      if (got.addr !== exp.addr || got.mask !== exp.mask || got.color !== exp.color ||
          got.last !== exp.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("row write mismatch: exp addr=%h mask=%h color=%h last=%b",
                   exp.addr, exp.mask, exp.color, exp.last);
          $display("                    got addr=%h mask=%h color=%h last=%b",
                   got.addr, got.mask, got.color, got.last);
        end
      end
    endfunction
  endclass

  render_scoreboard sb = new;

  bit          tx_calm;
  bit          rx_calm;
  int unsigned rx_hold;
  int unsigned rx_draw;
  int unsigned items_sent;
  int unsigned cfg_writes;
  logic [15:0] rows_seen [0:255];
  logic [7:0]  ready_glyphs[$];

  // output side: random stall after each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= 0;
    end else if (m_axis_tready) begin
      if (m_axis_tvalid) begin
        if ($urandom_range(0, 24) == 0) rx_calm = !rx_calm;
        rx_draw = rx_calm ? 0 : $urandom_range(0, 17);
        if (rx_draw != 0) begin
          m_axis_tready <= 1'b0;
          rx_hold       <= rx_draw;
        end
      end
    end else if (rx_hold <= 1) begin
      m_axis_tready <= 1'b1;
    end else begin
      rx_hold <= rx_hold - 1;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_row(m_axis_tdata, m_axis_tlast);

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d row writes outstanding", sb.expected_rows.size());
    $display("DONE: errors detected");
    $finish;
  end

  // called just after the clock rises; leaves tvalid high after the transfer
  task automatic send(text_req_t r);
    int unsigned gap;
    if ($urandom_range(0, 24) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.req_type;
    s_axis_tdata  <= {3'b000, r.color, r.sy, r.sx, r.first, r.bits, r.grow, r.code};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(r);
    items_sent++;
  endtask

  // wait until every predicted row write has arrived and the block is idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_rows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    cfg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_row(logic [7:0] code, logic [3:0] grow, logic [7:0] bits);
    text_req_t r;
    r          = '0;
    r.req_type = REQ_FONT_LOAD;
    r.code     = code;
    r.grow     = grow;
    r.bits     = bits;
    r.color    = $urandom();
    r.sx       = 12'($urandom());
    r.sy       = 12'($urandom());
    r.first    = 1'($urandom());
    send(r);
    rows_seen[code][grow] = 1'b1;
    if (&rows_seen[code] && code != NEWLINE_CODE && !(code inside {ready_glyphs}))
      ready_glyphs.push_back(code);
  endtask

  // all rows of one glyph, top row solid and second row empty
  task automatic load_glyph(logic [7:0] code);
    for (int g = 0; g < GLYPH_ROWS; g++)
      load_row(code, 4'(g), (g == 0) ? 8'hFF : (g == 1) ? 8'h00 : 8'($urandom()));
  endtask

  task automatic draw(logic [7:0] code, logic first, logic [11:0] sx, logic [11:0] sy,
                      logic [31:0] color);
    text_req_t r;
    r          = '0;
    r.req_type = !REQ_FONT_LOAD;
    r.code     = code;
    r.first    = first;
    r.sx       = sx;
    r.sy       = sy;
    r.color    = color;
    r.bits     = 8'($urandom());
    r.grow     = 4'($urandom());
    send(r);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 5))
      0:       return 13'd1;
      1:       return 13'd4096;
      2:       return 13'($urandom_range(1, 4096));
      default: return 13'($urandom_range(8, 200));
    endcase
  endfunction

  initial begin
    int unsigned base;
    int unsigned pick;
    int unsigned phase_left;
    int unsigned lim_x, lim_y;
    logic [11:0] sx, sy;

    for (int c = 0; c < 256; c++) rows_seen[c] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_glyph(8'hFF);
    load_glyph(8'h00);

    // reset screen size 640x480
    draw(8'hFF, 1'b1, 12'd0, 12'd0, 32'hFFFF_FFFF);
    draw(8'h00, 1'b0, 12'd0, 12'd0, 32'h0000_0000);
    draw(NEWLINE_CODE, 1'b0, 12'd0, 12'd0, $urandom());
    draw(8'hFF, 1'b0, 12'd0, 12'd0, $urandom());
    draw(NEWLINE_CODE, 1'b1, 12'd100, 12'd200, $urandom());  // first mark on a newline
    draw(8'hFF, 1'b0, 12'd0, 12'd0, $urandom());
    draw(8'hFF, 1'b1, 12'd636, 12'd470, $urandom());          // both edges clip
    draw(8'hFF, 1'b0, 12'd0, 12'd0, $urandom());
    draw(8'hFF, 1'b1, 12'hFFF, 12'hFFF, $urandom());
    settle();

    write_reg(CFG_SCREEN_WIDTH, 13'd1);
    write_reg(CFG_SCREEN_HEIGHT, 13'd1);
    draw(8'hFF, 1'b1, 12'd0, 12'd0, $urandom());
    draw(8'h00, 1'b1, 12'd0, 12'd1, $urandom());
    settle();

    // largest screen: last rows wrap the word address
    write_reg(CFG_SCREEN_WIDTH, 13'd4096);
    write_reg(CFG_SCREEN_HEIGHT, 13'd4096);
    draw(8'hFF, 1'b1, 12'd4095, 12'd4088, $urandom());
    draw(8'hFF, 1'b0, 12'd0, 12'd0, $urandom());
    draw(NEWLINE_CODE, 1'b0, 12'd0, 12'd0, $urandom());
    draw(8'h00, 1'b0, 12'd0, 12'd0, $urandom());
    settle();

    // cursor past the start range: row by newlines, column by advancing
    draw(NEWLINE_CODE, 1'b1, 12'd5, 12'd4095, $urandom());
    repeat (8) draw(NEWLINE_CODE, 1'b0, 12'd0, 12'd0, $urandom());
    draw(8'hFF, 1'b0, 12'd0, 12'd0, $urandom());
    settle();
    write_reg(CFG_SCREEN_HEIGHT, 13'd64);
    draw(8'hFF, 1'b1, 12'd4095, 12'd40, $urandom());
    repeat (12) draw(ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)], 1'b0,
                     12'd0, 12'd0, $urandom());
    settle();

    base = items_sent;
    phase_left = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        settle();
        write_reg(CFG_SCREEN_WIDTH, pick_dim());
        write_reg(CFG_SCREEN_HEIGHT, pick_dim());
        phase_left = $urandom_range(25, 45);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        lim_x = (sb.scr_width + 8 > 4095) ? 4095 : sb.scr_width + 8;
        lim_y = (sb.scr_height + 8 > 4095) ? 4095 : sb.scr_height + 8;
        if ($urandom_range(0, 3) == 0) begin
          sx = 12'($urandom());
          sy = 12'($urandom());
        end else begin
          sx = 12'($urandom_range(0, lim_x));
          sy = 12'($urandom_range(0, lim_y));
        end
        draw(ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)],
             ($urandom_range(0, 6) == 0), sx, sy, $urandom());
      end else if (pick < 72) begin
        draw(NEWLINE_CODE, ($urandom_range(0, 7) == 0), 12'($urandom()), 12'($urandom()),
             $urandom());
      end else if (pick < 88) begin
        load_row(8'($urandom()), 4'($urandom()), 8'($urandom()));
      end else if (pick < 95) begin
        load_glyph(8'($urandom()));
      end else begin
        settle();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.expected_rows.size() != 0) begin
      $display("%0d predicted row writes never arrived", sb.expected_rows.size());
      sb.mismatches += sb.expected_rows.size();
    end
    $display("covered %0d font rows loaded, %0d characters, %0d newlines, %0d register writes",
             sb.rows_loaded, sb.chars_drawn, sb.newlines, cfg_writes);
    $display("checked %0d row writes, %0d mismatches", sb.rows_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
